FILE: sv/sbb_pkg.sv
// Shared constants for the separable box blur block.
// No dependencies; imported by every module of the block.
package sbb_pkg;

    localparam int OUT_BITS     = 16;
    localparam int IN_BITS      = 16;
    localparam int W_CFG_BITS   = 11;
    localparam int H_CFG_BITS   = 13;
    localparam int R_CFG_BITS   = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam int MAX_HEIGHT = 4096;
    localparam int YW         = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 2'd2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

endpackage

FILE: sv/sbb_recip.sv
// Reciprocal unit: floor(2^K / win) by restoring division, one bit a cycle.
// Reloads after reset and after each start pulse. Uses sbb_pkg.
module sbb_recip #(
    parameter int K    = 23,
    parameter int WINW = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [WINW-1:0] win,
    output logic            busy,
    output logic [K:0]      recip
);
    import sbb_pkg::*;

    localparam int CW = $clog2(K + 1);

    logic            pend_reg;
    logic            run_reg;
    logic [CW-1:0]   cnt_reg;
    logic [WINW-1:0] rem_reg;
    logic [WINW-1:0] rem_next;
    logic [K:0]      quo_reg;
    logic [WINW:0]   sh;
    logic            qbit;

    always_comb
    begin
        // numerator is 2^K: only its top bit is set
        sh = {rem_reg, (cnt_reg == CW'(K))};
        if (sh >= {1'b0, win})
        begin
            rem_next = WINW'(sh - {1'b0, win});
            qbit     = 1'b1;
        end
        else
        begin
            rem_next = WINW'(sh);
            qbit     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b1;
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            pend_reg <= 1'b1;
        end
        else if (pend_reg)
        begin
            pend_reg <= 1'b0;
            run_reg  <= 1'b1;
            cnt_reg  <= CW'(K);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
                run_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && !start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[K-1:0], qbit};
        end
    end

    assign busy  = pend_reg | run_reg;
    assign recip = quo_reg;

endmodule

FILE: sv/sbb_div.sv
// Divide by the window size: multiply by reciprocal, then one-step correction.
// Three register stages. Uses sbb_pkg.
module sbb_div #(
    parameter int SUMW = 22,
    parameter int K    = 23,
    parameter int WINW = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_v,
    input  logic [SUMW-1:0] x,
    input  logic [K:0]      m,
    input  logic [WINW-1:0] win,
    output logic            out_v,
    output logic [SUMW-1:0] q
);
    import sbb_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [SUMW-1:0]      x1_reg, x2_reg;
    logic [SUMW-1:0]      q1_reg, q2_reg, q3_reg;
    logic [SUMW+WINW-1:0] back_reg;
    logic [SUMW+K:0]      prod;
    logic [SUMW-1:0]      diff;

    assign prod = (SUMW+K+1)'(x) * (SUMW+K+1)'(m);
    assign diff = x2_reg - SUMW'(back_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x;
        q1_reg   <= prod[K+SUMW-1:K];
        x2_reg   <= x1_reg;
        q2_reg   <= q1_reg;
        back_reg <= (SUMW+WINW)'(q1_reg) * (SUMW+WINW)'(win);
        // estimate is exact or one low
        q3_reg   <= (diff >= SUMW'(win)) ? q2_reg + 1'b1 : q2_reg;
    end

    assign out_v = v3_reg;
    assign q     = q3_reg;

endmodule

FILE: sv/separable_box_blur.sv
// Separable box blur, top level: line memory, frame counters, window sequencer.
// Depends on sbb_pkg, sbb_recip and sbb_div.
//
// Pixels enter in raster order, one per push item; flush items only drain.
// Each item first stores its pixel, then emits the next output pixel if every
// input it needs is present. For an item that emits, the window is gathered
// through the single read port of the line memory, one pixel a cycle, and each
// row sum goes through the three-stage reciprocal divider before the next row
// starts. After reset and after each register write, input stalls while the
// reciprocal unit (K = PIXEL_BITS + clog2(2*MAX_RADIUS+1) + 1) runs. Register
// writes are taken only while no item is in work, and a pending write holds
// off input items. The line memory holds 2*MAX_RADIUS+2 rows and is never
// cleared.
module separable_box_blur #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [sbb_pkg::IN_BITS-1:0]         pixel_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sbb_pkg::OUT_BITS-1:0]        pixel_out,
    output logic                                last_pixel,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sbb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import sbb_pkg::*;

    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RADW = $clog2(MAX_RADIUS + 1);
    localparam int WINW = $clog2(2 * MAX_RADIUS + 2);
    localparam int SUMW = PIXEL_BITS + $clog2(2 * MAX_RADIUS + 1);
    localparam int K    = SUMW + 1;
    localparam int RW   = $clog2(RING);
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int JW   = $clog2(2 * MAX_RADIUS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_ROW, S_READ, S_RDLAST, S_HDIV, S_HWAIT, S_VDIV, S_VWAIT, S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [W_CFG_BITS-1:0]   cfg_w_reg;
    logic [H_CFG_BITS-1:0]   cfg_h_reg;
    logic [R_CFG_BITS-1:0]   cfg_r_reg;
    logic [XW-1:0]           in_x_reg, out_x_reg;
    logic [YW-1:0]           in_y_reg, out_y_reg;
    logic [RW-1:0]           in_ring_reg, out_ring_reg;
    logic                    in_full_reg;
    logic [JW-1:0]           j_reg, i_reg;
    logic [AW-1:0]           base_reg;
    logic [SUMW-1:0]         hsum_reg, vsum_reg;
    logic                    rd_v_reg;
    logic [PIXEL_BITS-1:0]   rd_data_reg;
    logic [SUMW-1:0]         res_reg;
    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     pixel_out_reg;
    logic                    last_pixel_reg;

    logic [PIXEL_BITS-1:0]   mem [RING * MAX_WIDTH];

    logic [WW-1:0]           w_eff;
    logic [H_CFG_BITS-1:0]   h_eff;
    logic [RADW-1:0]         r_eff;
    logic [WINW-1:0]         win;
    logic                    in_acc, push, cfg_acc, cfg_hit;
    logic                    ready, emit, emit_last;
    logic [AW-1:0]           wr_addr, rd_addr, base_next;
    logic                    recip_busy;
    logic [K:0]              recip;
    logic                    div_in_v, div_v;
    logic [SUMW-1:0]         div_x, div_q;
    logic                    row_last, col_last;

    // effective sizes with out-of-range values clamped
    always_comb
    begin
        if (cfg_w_reg == '0)
            w_eff = WW'(1);
        else if (int'(cfg_w_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg_w_reg);
        if (cfg_h_reg == '0)
            h_eff = H_CFG_BITS'(1);
        else if (int'(cfg_h_reg) > MAX_HEIGHT)
            h_eff = H_CFG_BITS'(MAX_HEIGHT);
        else
            h_eff = cfg_h_reg;
        if (int'(cfg_r_reg) > MAX_RADIUS)
            r_eff = RADW'(MAX_RADIUS);
        else
            r_eff = RADW'(cfg_r_reg);
        win = WINW'(2 * int'(r_eff) + 1);
    end

    // a pending register write takes precedence over input items
    assign in_stall  = (state_reg != S_IDLE) || recip_busy || cfg_valid;
    assign cfg_ready = !recip_busy && (state_reg == S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign push      = in_acc && (opcode == OP_PUSH) && !in_full_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_acc && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                                   cfg_index == REG_RADIUS);
    assign emit      = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_last = (int'(out_x_reg) == int'(w_eff) - 1) &&
                       (int'(out_y_reg) == int'(h_eff) - 1);
    assign row_last  = (i_reg == JW'(2 * int'(r_eff)));
    assign col_last  = (j_reg == JW'(2 * int'(r_eff)));
    assign wr_addr   = AW'(int'(in_ring_reg) * MAX_WIDTH + int'(in_x_reg));

    // is the last input of the next output's window present
    always_comb
    begin
        int nx, ny;
        nx = int'(out_x_reg) + int'(r_eff);
        if (nx > int'(w_eff) - 1)
            nx = int'(w_eff) - 1;
        ny = int'(out_y_reg) + int'(r_eff);
        if (ny > int'(h_eff) - 1)
            ny = int'(h_eff) - 1;
        ready = in_full_reg || (int'(in_y_reg) > ny) ||
                ((int'(in_y_reg) == ny) && (int'(in_x_reg) > nx));
    end

    // ring row of the clamped window row, and clamped column address
    always_comb
    begin
        int yy, rg, xx;
        yy = int'(out_y_reg) + int'(j_reg) - int'(r_eff);
        if (yy < 0)
            yy = 0;
        else if (yy > int'(h_eff) - 1)
            yy = int'(h_eff) - 1;
        rg = int'(out_ring_reg) + yy - int'(out_y_reg);
        if (rg < 0)
            rg = rg + RING;
        else if (rg >= RING)
            rg = rg - RING;
        base_next = AW'(rg * MAX_WIDTH);
        xx = int'(out_x_reg) + int'(i_reg) - int'(r_eff);
        if (xx < 0)
            xx = 0;
        else if (xx > int'(w_eff) - 1)
            xx = int'(w_eff) - 1;
        rd_addr = base_reg + AW'(xx);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_addr] <= pixel_in[PIXEL_BITS-1:0];
        if (state_reg == S_READ)
            rd_data_reg <= mem[rd_addr];
    end

    sbb_recip #(.K(K), .WINW(WINW)) u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_hit),
        .win   (win),
        .busy  (recip_busy),
        .recip (recip)
    );

    assign div_in_v = (state_reg == S_HDIV) || (state_reg == S_VDIV);
    assign div_x    = (state_reg == S_HDIV) ? hsum_reg : vsum_reg;

    sbb_div #(.SUMW(SUMW), .K(K), .WINW(WINW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .in_v  (div_in_v),
        .x     (div_x),
        .m     (recip),
        .win   (win),
        .out_v (div_v),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_w_reg      <= W_CFG_BITS'(1024);
            cfg_h_reg      <= H_CFG_BITS'(768);
            cfg_r_reg      <= R_CFG_BITS'(1);
            in_x_reg       <= '0;
            in_y_reg       <= '0;
            in_ring_reg    <= '0;
            in_full_reg    <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_ring_reg   <= '0;
            j_reg          <= '0;
            i_reg          <= '0;
            rd_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pixel_out_reg  <= '0;
            last_pixel_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (state_reg == S_READ);
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  cfg_w_reg <= cfg_data[W_CFG_BITS-1:0];
                    REG_HEIGHT: cfg_h_reg <= cfg_data[H_CFG_BITS-1:0];
                    default:    cfg_r_reg <= cfg_data[R_CFG_BITS-1:0];
                endcase
                in_x_reg     <= '0;
                in_y_reg     <= '0;
                in_ring_reg  <= '0;
                in_full_reg  <= 1'b0;
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_ring_reg <= '0;
            end

            if (push)
            begin
                if (int'(in_x_reg) + 1 < int'(w_eff))
                    in_x_reg <= in_x_reg + 1'b1;
                else
                begin
                    in_x_reg <= '0;
                    if (int'(in_y_reg) + 1 < int'(h_eff))
                    begin
                        in_y_reg    <= in_y_reg + 1'b1;
                        in_ring_reg <= (in_ring_reg == RW'(RING - 1)) ? '0 :
                                       in_ring_reg + 1'b1;
                    end
                    else
                        in_full_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                        state_reg <= S_EVAL;
                S_EVAL:
                begin
                    j_reg     <= '0;
                    state_reg <= ready ? S_ROW : S_IDLE;
                end
                S_ROW:
                begin
                    i_reg     <= '0;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (row_last)
                        state_reg <= S_RDLAST;
                end
                S_RDLAST:
                    state_reg <= S_HDIV;
                S_HDIV:
                    state_reg <= S_HWAIT;
                S_HWAIT:
                    if (div_v)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= col_last ? S_VDIV : S_ROW;
                    end
                S_VDIV:
                    state_reg <= S_VWAIT;
                S_VWAIT:
                    if (div_v)
                        state_reg <= S_EMIT;
                S_EMIT:
                    if (emit)
                    begin
                        pixel_out_reg  <= OUT_BITS'(res_reg[PIXEL_BITS-1:0]);
                        last_pixel_reg <= emit_last;
                        state_reg      <= S_IDLE;
                        if (emit_last)
                        begin
                            in_x_reg     <= '0;
                            in_y_reg     <= '0;
                            in_ring_reg  <= '0;
                            in_full_reg  <= 1'b0;
                            out_x_reg    <= '0;
                            out_y_reg    <= '0;
                            out_ring_reg <= '0;
                        end
                        else if (int'(out_x_reg) + 1 < int'(w_eff))
                            out_x_reg <= out_x_reg + 1'b1;
                        else
                        begin
                            out_x_reg    <= '0;
                            out_y_reg    <= out_y_reg + 1'b1;
                            out_ring_reg <= (out_ring_reg == RW'(RING - 1)) ? '0 :
                                            out_ring_reg + 1'b1;
                        end
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW)
        begin
            base_reg <= base_next;
            hsum_reg <= '0;
        end
        else if (rd_v_reg)
            hsum_reg <= hsum_reg + SUMW'(rd_data_reg);

        if (state_reg == S_EVAL)
            vsum_reg <= '0;
        else if (state_reg == S_HWAIT && div_v)
            vsum_reg <= vsum_reg + div_q;

        if (state_reg == S_VWAIT && div_v)
            res_reg <= div_q;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign last_pixel = last_pixel_reg;

    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_v |-> (state_reg == S_HWAIT || state_reg == S_VWAIT))
        else $error("divider result outside a wait state");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_EVAL))
        else $error("accepted item not evaluated");

    a_in_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(in_x_reg) < int'(w_eff))
        else $error("input column beyond row width");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (out_x_reg == '0 && out_y_reg == '0 && !in_full_reg))
        else $error("frame not restarted after last pixel");

endmodule
